// ===== src/bsesc_pkg.sv =====
// Shared types and constants for the backslash escape decoder.
`timescale 1ns / 1ps
`default_nettype none

package bsesc_pkg;

  localparam int unsigned MaxRun = 4;

  // Parser mode, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_SLASH  = 3'b010,
    MODE_DIGITS = 3'b100
  } parse_mode_t;

  // Kind of numeric escape being collected
  typedef enum logic [1:0] {
    KIND_HEX2 = 2'd0,
    KIND_HEX4 = 2'd1,
    KIND_OCT3 = 2'd2
  } escape_kind_t;

  // Parser state carried from one text byte to the next
  typedef struct packed {
    parse_mode_t  mode;
    escape_kind_t kind;
    logic [2:0]   digit_count;
    logic [15:0]  code_value;
  } parse_state_t;

  localparam parse_state_t ParseReset = '{
    mode: MODE_IDLE, kind: KIND_HEX2, digit_count: 3'd0, code_value: 16'd0
  };

  // Decoded bytes caused by one text byte
  typedef struct packed {
    logic [MaxRun-1:0][7:0] data;
    logic [2:0]             count;
  } run_t;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChX         = 8'h78;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChZero      = 8'h30;

endpackage

`default_nettype wire

// ===== src/bsesc_decode.sv =====
// Combinational decode of one text byte against the parser state.
`timescale 1ns / 1ps
`default_nettype none

module bsesc_decode (
  input  var bsesc_pkg::parse_state_t state,
  input  var logic [7:0]              in_byte,
  input  var logic                    text_end,
  output bsesc_pkg::parse_state_t     state_next,
  output bsesc_pkg::run_t             run
);
  import bsesc_pkg::*;

  logic [3:0]  digit;
  logic        digit_ok;
  logic [15:0] value_new;
  logic [2:0]  count_new;
  logic [2:0]  limit;
  logic [7:0]  letter;
  logic [7:0]  ctrl_byte;
  logic        ctrl_ok;

  // Classify the byte as a digit of the pending escape kind
  always_comb begin
    digit    = 4'd0;
    digit_ok = 1'b0;
    if (state.kind == KIND_OCT3) begin
      if (in_byte >= 8'h30 && in_byte <= 8'h37) begin
        digit    = 4'(in_byte - 8'h30);
        digit_ok = 1'b1;
      end
    end else if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      digit    = 4'(in_byte - 8'h30);
      digit_ok = 1'b1;
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      digit    = 4'(in_byte - 8'h57);
      digit_ok = 1'b1;
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      digit    = 4'(in_byte - 8'h37);
      digit_ok = 1'b1;
    end
  end

  // Shift the digit into the value and look up the digit limit
  always_comb begin
    if (state.kind == KIND_OCT3) begin
      value_new = {state.code_value[12:0], digit[2:0]};
    end else begin
      value_new = {state.code_value[11:0], digit};
    end
    count_new = state.digit_count + 3'd1;
    case (state.kind)
      KIND_HEX2: begin limit = 3'd2; letter = ChX; end
      KIND_HEX4: begin limit = 3'd4; letter = ChU; end
      KIND_OCT3: begin limit = 3'd3; letter = ChZero; end
      default:   begin limit = 3'd2; letter = ChX; end
    endcase
  end

  // Map simple escape letters to control bytes
  always_comb begin
    ctrl_ok = 1'b1;
    case (in_byte)
      8'h61:       ctrl_byte = 8'h07;
      8'h62:       ctrl_byte = 8'h08;
      8'h74:       ctrl_byte = 8'h09;
      8'h6E:       ctrl_byte = 8'h0A;
      8'h76:       ctrl_byte = 8'h0B;
      8'h66:       ctrl_byte = 8'h0C;
      8'h72:       ctrl_byte = 8'h0D;
      8'h65:       ctrl_byte = 8'h1B;
      ChBackslash: ctrl_byte = ChBackslash;
      default: begin
        ctrl_byte = ChBackslash;
        ctrl_ok   = 1'b0;
      end
    endcase
  end

  // Build the run of output bytes and the next state
  always_comb begin
    logic [15:0] v;
    logic        emit_val;
    logic        do_plain;
    state_next = state;
    run        = '0;
    emit_val   = 1'b0;
    do_plain   = 1'b0;
    v          = state.code_value;

    case (state.mode)
      MODE_SLASH: begin
        state_next.mode = MODE_IDLE;
        if (in_byte == ChX || in_byte == ChU || in_byte == ChZero) begin
          if (text_end) begin
            run.data[0] = in_byte;
            run.count   = 3'd1;
          end else begin
            state_next.mode        = MODE_DIGITS;
            state_next.kind        = (in_byte == ChX) ? KIND_HEX2 :
                                     (in_byte == ChU) ? KIND_HEX4 : KIND_OCT3;
            state_next.digit_count = 3'd0;
            state_next.code_value  = 16'd0;
          end
        end else if (ctrl_ok) begin
          run.data[0] = ctrl_byte;
          run.count   = 3'd1;
        end else begin
          run.data[0] = ChBackslash;
          run.data[1] = in_byte;
          run.count   = 3'd2;
        end
      end
      MODE_DIGITS: begin
        if (digit_ok) begin
          state_next.code_value  = value_new;
          state_next.digit_count = count_new;
          v = value_new;
          if (count_new >= limit || text_end) begin
            emit_val        = 1'b1;
            state_next.mode = MODE_IDLE;
          end
        end else begin
          do_plain = 1'b1;
          if (state.digit_count != 3'd0) begin
            emit_val = 1'b1;
          end else begin
            run.data[0] = letter;
            run.count   = 3'd1;
          end
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    // Emit the collected value as UTF-8
    if (emit_val) begin
      if (v <= 16'h007F) begin
        run.data[0] = v[7:0];
        run.count   = 3'd1;
      end else if (v <= 16'h07FF) begin
        run.data[0] = 8'hC0 | {3'b000, v[10:6]};
        run.data[1] = 8'h80 | {2'b00, v[5:0]};
        run.count   = 3'd2;
      end else begin
        run.data[0] = 8'hE0 | {4'b0000, v[15:12]};
        run.data[1] = 8'h80 | {2'b00, v[11:6]};
        run.data[2] = 8'h80 | {2'b00, v[5:0]};
        run.count   = 3'd3;
      end
    end

    // Treat the byte as ordinary text after whatever is already queued
    if (do_plain) begin
      state_next.mode = MODE_IDLE;
      if (in_byte == ChBackslash && !text_end) begin
        state_next.mode = MODE_SLASH;
      end else begin
        run.data[run.count[1:0]] = in_byte;
        run.count                = run.count + 3'd1;
      end
    end

    if (text_end) begin
      state_next = ParseReset;
    end
  end

endmodule

`default_nettype wire

// ===== src/backslash_escape_decoder_unit.sv =====
// Top level of the backslash escape decoder: input register, parser state, run buffer.
`timescale 1ns / 1ps
`default_nettype none

// Decodes C-style backslash escapes in a byte stream, writing numeric escapes
// (\xHH, \uHHHH, \0OOO) as UTF-8.
// Input channel s_axis: one text byte per transfer in s_axis_tdata, with
// s_axis_tlast on the final byte of a text. Output channel m_axis: one decoded
// byte per transfer; m_axis_tuser marks the last byte caused by one input byte
// and m_axis_tlast the final byte of the whole text.
// A byte accepted into the input register is decoded into the run buffer once
// the run buffer is free, and its first output byte is offered from there.
// Throughput: one input byte per cycle while each causes at most one output
// byte and the receiver is ready. A byte that causes n output bytes holds the
// run buffer until all n are taken, so the output port (one byte per cycle)
// sets the rate; bytes that cause no output leave the run buffer free.
// An input register sits in front of the run buffer, so one input byte is
// taken while the receiver stalls; further input waits until the run buffer
// drains. Reset clears both stages and returns the parser to idle.

module backslash_escape_decoder_unit (
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       s_axis_tvalid,
  output logic           s_axis_tready,
  input  var logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  var logic       s_axis_tlast,   // text_end
  output logic           m_axis_tvalid,
  input  var logic       m_axis_tready,
  output logic [7:0]     m_axis_tdata,   // [7:0] out_byte
  output logic           m_axis_tuser,   // run_last
  output logic           m_axis_tlast    // stream_last
);
  import bsesc_pkg::*;

  logic                   in_full;
  logic [7:0]             in_byte;
  logic                   in_end;
  parse_state_t           state;
  parse_state_t           state_next;
  run_t                   dec_run;
  logic                   run_valid;
  logic [MaxRun-1:0][7:0] run_data;
  logic [2:0]             run_cnt;
  logic [1:0]             run_idx;
  logic                   run_end;
  logic [2:0]             run_top;
  logic                   last_beat;
  logic                   run_free;
  logic                   move;

  bsesc_decode u_decode (
    .state      (state),
    .in_byte    (in_byte),
    .text_end   (in_end),
    .state_next (state_next),
    .run        (dec_run)
  );

  // Handshake control between the stages
  assign run_top   = run_cnt - 3'd1;
  assign last_beat = run_valid && (run_idx == run_top[1:0]);
  assign run_free  = !run_valid || (m_axis_tready && last_beat);
  assign move      = in_full && run_free;

  assign s_axis_tready = !in_full || run_free;
  assign m_axis_tvalid = run_valid;
  assign m_axis_tdata  = run_data[run_idx];
  assign m_axis_tuser  = last_beat;
  assign m_axis_tlast  = last_beat && run_end;

  // Input register: hold the transfer until the decoder takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_end  <= s_axis_tlast;
    end
  end

  // Parser state: advance once per decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ParseReset;
    end else if (move) begin
      state <= state_next;
    end
  end

  // Run buffer control: load on decode, advance on each output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      run_idx   <= 2'd0;
    end else if (move) begin
      run_valid <= (dec_run.count != 3'd0);
      run_idx   <= 2'd0;
    end else if (run_free) begin
      run_valid <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      run_idx <= run_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      run_data <= dec_run.data;
      run_cnt  <= dec_run.count;
      run_end  <= in_end;
    end
  end

  // A valid run holds at least one and at most four bytes
  assert property (@(posedge clk) disable iff (rst)
    run_valid |-> (run_cnt != 3'd0 && run_cnt <= 3'd4))
    else $error("run buffer valid with bad byte count");

  // End of text is flagged only on the last byte of a run
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tlast |-> m_axis_tuser)
    else $error("stream end outside run end");

  // A waiting input byte is held while the run buffer is busy
  assert property (@(posedge clk) disable iff (rst)
    (in_full && run_valid && !m_axis_tready) |=> in_full)
    else $error("input byte dropped during stall");

  // A mid-run transfer steps to the next byte of the same run
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !last_beat) |=>
      (run_valid && run_idx == $past(run_idx) + 2'd1))
    else $error("run index did not advance");

endmodule

`default_nettype wire
